// ===== design/go_back_n_sender_window_macros.svh =====
// Assertion macros shared by the sender window design.
`ifndef GO_BACK_N_SENDER_WINDOW_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gbn_pkg.sv =====
`default_nettype none

package gbn_pkg;

  localparam int SEQ_BITS       = 16;
  localparam int TIME_BITS      = 32;
  localparam int WINDOW_MAX_DEF = 8;
  localparam int WIN_CFG_BITS   = 4;
  localparam int TIMEOUT_BITS   = 16;
  localparam int PCOUNT_BITS    = 16;
  localparam int KIND_BITS      = 2;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Event kinds.
  localparam logic [KIND_BITS-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_SEND = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_ACK  = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PCOUNT  = 2'd2;

  // Register reset values.
  localparam logic [WIN_CFG_BITS-1:0] WINDOW_RST  = 4'd5;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST = 16'd500;
  localparam logic [PCOUNT_BITS-1:0]  PCOUNT_RST  = 16'd1;

endpackage

`default_nettype wire

// ===== design/go_back_n_sender_window.sv =====
// Go-Back-N sender window controller.
// Input channel (in_valid/in_ready) carries one event per transfer: a clock
// tick, a send slot, or a received acknowledgement with its flags and number.
// Output channel (out_valid/out_ready) returns exactly one result per event:
// the packet to send, if any, the timeout flag and the window status.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// window_size, timeout_ticks and packet_count; it is always ready and should
// only be used while no result is pending.
// A result is loaded into the output register at the edge that accepts its
// event. Throughput is one event per cycle while the receiver keeps out_ready high.
// Send times are kept in a small ring memory; its read port always points at
// the entry of the next head, so the oldest send time is ready in the cycle
// after any update, with a same-cycle write forwarded to the read data.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until it is taken. Reset clears the window state, the tick
// counter and the registers to their defaults; the time memory is not cleared.
`default_nettype none

`include "go_back_n_sender_window_macros.svh"

module go_back_n_sender_window #(
  parameter int WINDOW_MAX = gbn_pkg::WINDOW_MAX_DEF,
  localparam int CNT_W = $clog2(WINDOW_MAX + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [gbn_pkg::KIND_BITS-1:0]      kind,
  input  wire logic                               ack_flag,
  input  wire logic                               nak_flag,
  input  wire logic [gbn_pkg::SEQ_BITS-1:0]       ack_number,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    send_valid,
  output logic      [gbn_pkg::SEQ_BITS-1:0]       send_seq,
  output logic                                    send_last,
  output logic                                    timed_out,
  output logic                                    done_res,
  output logic      [gbn_pkg::SEQ_BITS-1:0]       window_base,
  output logic      [CNT_W-1:0]                   outstanding,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [gbn_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [gbn_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SEQ_W  = gbn_pkg::SEQ_BITS;
  localparam int TIME_W = gbn_pkg::TIME_BITS;
  localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int EW     = (CNT_W > gbn_pkg::WIN_CFG_BITS) ? CNT_W : gbn_pkg::WIN_CFG_BITS;
  localparam int SW     = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

  // Configuration registers.
  logic [gbn_pkg::WIN_CFG_BITS-1:0] window_size;
  logic [gbn_pkg::TIMEOUT_BITS-1:0] timeout_ticks;
  logic [gbn_pkg::PCOUNT_BITS-1:0]  packet_count;

  // Window state.
  logic [SEQ_W-1:0]  base_seq, base_seq_next;
  logic [SEQ_W-1:0]  next_seq, next_seq_next;
  logic [CNT_W-1:0]  in_flight, in_flight_next;
  logic [IDX_W-1:0]  ring_head, ring_head_next;
  logic [TIME_W-1:0] now_count, now_count_next;

  logic              in_fire;
  logic [TIME_W-1:0] head_time;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [EW-1:0]     win_eff;
  logic [SW-1:0]     slot_sum;
  logic              tick_expire;
  logic [SEQ_W-1:0]  seq_gap;

  logic             res_send_valid;
  logic [SEQ_W-1:0] res_send_seq;
  logic             res_send_last;
  logic             res_timed_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= gbn_pkg::WINDOW_RST;
      timeout_ticks <= gbn_pkg::TIMEOUT_RST;
      packet_count  <= gbn_pkg::PCOUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        gbn_pkg::REG_WINDOW:  window_size   <= cfg_data[gbn_pkg::WIN_CFG_BITS-1:0];
        gbn_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data[gbn_pkg::TIMEOUT_BITS-1:0];
        gbn_pkg::REG_PCOUNT:  packet_count  <= cfg_data[gbn_pkg::PCOUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A window of zero acts as one; anything above the ring depth is clamped.
  always_comb begin
    win_eff = EW'(window_size);
    if (win_eff == '0) begin
      win_eff = EW'(1);
    end
    if (win_eff > EW'(WINDOW_MAX)) begin
      win_eff = EW'(WINDOW_MAX);
    end
  end

  // Free slot of the ring: head plus the outstanding count, wrapped once.
  always_comb begin
    slot_sum = SW'(ring_head) + SW'(in_flight);
    if (slot_sum >= SW'(WINDOW_MAX)) begin
      slot_sum = slot_sum - SW'(WINDOW_MAX);
    end
  end
  assign wr_addr = slot_sum[IDX_W-1:0];

  always_comb begin
    base_seq_next  = base_seq;
    next_seq_next  = next_seq;
    in_flight_next = in_flight;
    ring_head_next = ring_head;
    now_count_next = now_count;
    wr_en          = 1'b0;
    tick_expire    = 1'b0;
    res_send_valid = 1'b0;
    res_send_seq   = '0;
    res_send_last  = 1'b0;
    res_timed_out  = 1'b0;
    if (in_fire) begin
      case (kind)
        gbn_pkg::KIND_TICK: begin
          now_count_next = now_count + TIME_W'(1);
          if ((in_flight != '0) &&
              ((now_count_next - head_time) > TIME_W'(timeout_ticks))) begin
            tick_expire    = 1'b1;
            next_seq_next  = base_seq;
            in_flight_next = '0;
            res_timed_out  = 1'b1;
          end
        end
        gbn_pkg::KIND_SEND: begin
          if ((EW'(in_flight) < win_eff) && (next_seq < packet_count)) begin
            wr_en          = 1'b1;
            res_send_valid = 1'b1;
            res_send_seq   = next_seq;
            res_send_last  = ({1'b0, next_seq} + 17'd1) == {1'b0, packet_count};
            next_seq_next  = next_seq + SEQ_W'(1);
            in_flight_next = in_flight + CNT_W'(1);
          end
        end
        gbn_pkg::KIND_ACK: begin
          if (ack_flag && !nak_flag && (in_flight != '0) &&
              (ack_number == (base_seq + SEQ_W'(1)))) begin
            base_seq_next  = base_seq + SEQ_W'(1);
            in_flight_next = in_flight - CNT_W'(1);
            if (ring_head == IDX_W'(WINDOW_MAX - 1)) begin
              ring_head_next = '0;
            end else begin
              ring_head_next = ring_head + IDX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // The read port follows the head after this cycle's update, so head_time
  // always holds the send time of the oldest outstanding packet.
  gbn_time_ram #(
    .DEPTH  (WINDOW_MAX),
    .DATA_W (TIME_W)
  ) u_time_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (now_count),
    .rd_addr (ring_head_next),
    .rd_data (head_time)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq  <= '0;
      next_seq  <= '0;
      in_flight <= '0;
      ring_head <= '0;
      now_count <= '0;
    end else begin
      base_seq  <= base_seq_next;
      next_seq  <= next_seq_next;
      in_flight <= in_flight_next;
      ring_head <= ring_head_next;
      now_count <= now_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      send_valid  <= res_send_valid;
      send_seq    <= res_send_seq;
      send_last   <= res_send_last;
      timed_out   <= res_timed_out;
      done_res    <= base_seq_next >= packet_count;
      window_base <= base_seq_next;
      outstanding <= in_flight_next;
    end
  end

  assign seq_gap = next_seq - base_seq;

  `GBN_ASSERT_NOW(a_flight_bound, clk, rst, 1'b1, in_flight <= CNT_W'(WINDOW_MAX), "in_flight exceeds ring depth")
  `GBN_ASSERT_NOW(a_seq_gap, clk, rst, 1'b1, seq_gap == SEQ_W'(in_flight), "next_seq and base_seq disagree with in_flight")
  `GBN_ASSERT_NEXT(a_timeout_flush, clk, rst, tick_expire, out_valid && timed_out && (in_flight == '0) && (next_seq == base_seq), "timeout did not flush the window")

endmodule

`default_nettype wire

// ===== design/gbn_time_ram.sv =====
`default_nettype none

module gbn_time_ram #(
  parameter int DEPTH = gbn_pkg::WINDOW_MAX_DEF,
  parameter int DATA_W = gbn_pkg::TIME_BITS,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A write to the entry being read in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam logic [gbn_pkg::KIND_BITS-1:0]    KIND_NONE  = 2'd3;
  localparam logic [gbn_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int WIN_MAX          = gbn_pkg::WINDOW_MAX_DEF;
  localparam int STALL_LIMIT      = 2000;
  localparam int PHASES           = 10;
  localparam int EVENTS_PER_PHASE = 150;
  localparam int IDLE_PCT         = 22;
  localparam int REPORT_MAX       = 10;

  typedef struct packed {
    logic                         issued;
    logic [gbn_pkg::SEQ_BITS-1:0] seq;
    logic                         last;
    logic                         expired;
    logic                         done;
    logic [gbn_pkg::SEQ_BITS-1:0] base;
    logic [3:0]                   count;
  } window_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              in_valid   = 1'b0;
  logic                              in_ready;
  logic [gbn_pkg::KIND_BITS-1:0]     kind       = gbn_pkg::KIND_TICK;
  logic                              ack_flag   = 1'b0;
  logic                              nak_flag   = 1'b0;
  logic [gbn_pkg::SEQ_BITS-1:0]      ack_number = '0;
  logic                              out_valid;
  logic                              out_ready  = 1'b0;
  logic                              send_valid;
  logic [gbn_pkg::SEQ_BITS-1:0]      send_seq;
  logic                              send_last;
  logic                              timed_out;
  logic                              done_res;
  logic [gbn_pkg::SEQ_BITS-1:0]      window_base;
  logic [3:0]                        outstanding;
  logic                              cfg_valid  = 1'b0;
  logic                              cfg_ready;
  logic [gbn_pkg::CFG_IDX_BITS-1:0]  cfg_index  = gbn_pkg::REG_WINDOW;
  logic [gbn_pkg::CFG_DATA_BITS-1:0] cfg_data   = '0;

  // Shadow copy of the window state and registers.
  logic [gbn_pkg::WIN_CFG_BITS-1:0] cfg_window  = gbn_pkg::WINDOW_RST;
  logic [gbn_pkg::TIMEOUT_BITS-1:0] cfg_timeout = gbn_pkg::TIMEOUT_RST;
  logic [gbn_pkg::PCOUNT_BITS-1:0]  cfg_pcount  = gbn_pkg::PCOUNT_RST;
  logic [gbn_pkg::SEQ_BITS-1:0]     cur_base    = '0;
  logic [gbn_pkg::SEQ_BITS-1:0]     cur_next    = '0;
  logic [3:0]                       cur_flight  = '0;
  logic [2:0]                       cur_head    = '0;
  logic [gbn_pkg::TIME_BITS-1:0]    tick_count  = '0;
  logic [gbn_pkg::TIME_BITS-1:0]    sent_at [WIN_MAX] = '{default: '0};

  window_status_t status_queue[$];
  window_status_t got_status;
  window_status_t want_status;

  logic no_idle = 1'b0;
  int events_sent  = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int packets      = 0;
  int acks         = 0;
  int timeouts     = 0;
  int quiet        = 0;

  go_back_n_sender_window u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .ack_flag    (ack_flag),
    .nak_flag    (nak_flag),
    .ack_number  (ack_number),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .send_valid  (send_valid),
    .send_seq    (send_seq),
    .send_last   (send_last),
    .timed_out   (timed_out),
    .done_res    (done_res),
    .window_base (window_base),
    .outstanding (outstanding),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one accepted event to the shadow window and queues the status it yields.
  task automatic advance_window(input logic [gbn_pkg::KIND_BITS-1:0] k, input logic a,
                                input logic n, input logic [gbn_pkg::SEQ_BITS-1:0] num);
    window_status_t r;
    logic [3:0] limit;
    logic [2:0] slot;
    r = '0;
    limit = (cfg_window == 0) ? 4'd1 : (cfg_window > WIN_MAX) ? 4'(WIN_MAX) : cfg_window;
    case (k)
      gbn_pkg::KIND_TICK: begin
        tick_count = tick_count + 1'b1;
        // The age of the oldest packet is taken modulo the counter width.
        if (cur_flight != 0 && (tick_count - sent_at[cur_head]) > 32'(cfg_timeout)) begin
          cur_next = cur_base;
          cur_flight = '0;
          r.expired = 1'b1;
          timeouts++;
        end
      end
      gbn_pkg::KIND_SEND: if (cur_flight < limit && cur_next < cfg_pcount) begin
        slot = cur_head + cur_flight[2:0];
        sent_at[slot] = tick_count;
        r.issued = 1'b1;
        r.seq = cur_next;
        r.last = ({1'b0, cur_next} + 17'd1) == {1'b0, cfg_pcount};
        cur_next = cur_next + 1'b1;
        cur_flight = cur_flight + 1'b1;
        packets++;
      end
      gbn_pkg::KIND_ACK: if (a && !n && cur_flight != 0 && num == cur_base + 1'b1) begin
        cur_base = cur_base + 1'b1;
        cur_flight = cur_flight - 1'b1;
        cur_head = cur_head + 1'b1;
        acks++;
      end
      default: ;
    endcase
    r.done = cur_base >= cfg_pcount;
    r.base = cur_base;
    r.count = cur_flight;
    status_queue.push_back(r);
  endtask

  // Valid stays high from one event to the next unless idle cycles are drawn.
  task automatic offer_event(input logic [gbn_pkg::KIND_BITS-1:0] k, input logic a,
                             input logic n, input logic [gbn_pkg::SEQ_BITS-1:0] num);
    int gap;
    gap = 0;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    ack_flag   <= a;
    nak_flag   <= n;
    ack_number <= num;
    do @(posedge clk); while (!in_ready);
    events_sent++;
    advance_window(k, a, n, num);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [gbn_pkg::CFG_IDX_BITS-1:0] idx,
                                input logic [gbn_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      gbn_pkg::REG_WINDOW:  cfg_window  = data[gbn_pkg::WIN_CFG_BITS-1:0];
      gbn_pkg::REG_TIMEOUT: cfg_timeout = data;
      gbn_pkg::REG_PCOUNT:  cfg_pcount  = data;
      default: ;
    endcase
  endtask

  // Reset values: a one-packet transfer, five-deep window.
  task automatic test_reset_defaults();
    offer_event(gbn_pkg::KIND_SEND, 1'b0, 1'b0, 16'h0000);
    offer_event(gbn_pkg::KIND_SEND, 1'b1, 1'b1, 16'hFFFF);
    offer_event(KIND_NONE, 1'b1, 1'b1, 16'hFFFF);
    offer_event(gbn_pkg::KIND_ACK, 1'b1, 1'b0, 16'h0001);
  endtask

  // A zero window acts as one, an oversized window as the maximum.
  task automatic test_window_clamp();
    drain_results();
    write_register(gbn_pkg::REG_WINDOW, 16'h0000);
    write_register(gbn_pkg::REG_TIMEOUT, 16'hFFFF);
    write_register(gbn_pkg::REG_PCOUNT, 16'd13);
    offer_event(gbn_pkg::KIND_SEND, 1'b0, 1'b0, 16'h0000);
    offer_event(gbn_pkg::KIND_SEND, 1'b0, 1'b0, 16'h0000);
    drain_results();
    write_register(gbn_pkg::REG_WINDOW, 16'hFFFF);
    repeat (8) offer_event(gbn_pkg::KIND_SEND, 1'b0, 1'b0, 16'h0000);
  endtask

  // Acknowledgements with NAK, without ACK or with a wrong number leave the window alone; a correct one follows.
  task automatic test_stray_acks();
    offer_event(gbn_pkg::KIND_ACK, 1'b1, 1'b1, cur_base + 1'b1);
    offer_event(gbn_pkg::KIND_ACK, 1'b0, 1'b0, cur_base + 1'b1);
    offer_event(gbn_pkg::KIND_ACK, 1'b1, 1'b0, cur_base + 2'd2);
    offer_event(gbn_pkg::KIND_ACK, 1'b1, 1'b0, 16'hFFFF);
    offer_event(gbn_pkg::KIND_ACK, 1'b1, 1'b0, cur_base + 1'b1);
  endtask

  task automatic test_timeouts();
    drain_results();
    write_register(gbn_pkg::REG_TIMEOUT, 16'd0);
    offer_event(gbn_pkg::KIND_TICK, 1'b0, 1'b0, 16'h0000);
    drain_results();
    write_register(gbn_pkg::REG_TIMEOUT, 16'd2);
    offer_event(gbn_pkg::KIND_SEND, 1'b0, 1'b0, 16'h0000);
    repeat (3) offer_event(gbn_pkg::KIND_TICK, 1'b0, 1'b0, 16'h0000);
  endtask

  // An empty transfer sends nothing; an unknown register index is ignored.
  task automatic test_transfer_finished();
    logic [gbn_pkg::CFG_DATA_BITS-1:0] junk;
    junk = 16'($urandom_range(0, 65535));
    drain_results();
    write_register(gbn_pkg::REG_PCOUNT, 16'd0);
    write_register(REG_UNUSED, junk);
    offer_event(gbn_pkg::KIND_SEND, 1'b0, 1'b0, 16'h0000);
    offer_event(gbn_pkg::KIND_ACK, 1'b1, 1'b0, cur_base + 1'b1);
  endtask

  // Mostly in-order traffic with correct acknowledgements, plus ticks and noise.
  task automatic test_random_traffic();
    int counted;
    int pick;
    int p;
    logic paused;
    logic [gbn_pkg::CFG_DATA_BITS-1:0] wdata;
    logic [gbn_pkg::SEQ_BITS-1:0] rnd;
    for (p = 0; p < PHASES; p++) begin
      drain_results();
      wdata = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 9);
      if (p == 0) wdata[3:0] = 4'd1;
      else if (p == 1) wdata[3:0] = 4'd8;
      else if (pick == 0) wdata[3:0] = 4'd0;
      else if (pick == 1) wdata[3:0] = 4'($urandom_range(9, 15));
      else wdata[3:0] = 4'($urandom_range(1, 8));
      write_register(gbn_pkg::REG_WINDOW, wdata);
      if (p == 2) wdata = 16'hFFFF;
      else if (p == 3) wdata = 16'd1;
      else wdata = 16'($urandom_range(0, 25));
      write_register(gbn_pkg::REG_TIMEOUT, wdata);
      if (p == 4) wdata = 16'hFFFF;
      else if (p == 6) wdata = cur_base;
      else wdata = cur_base + 16'($urandom_range(1, 40));
      write_register(gbn_pkg::REG_PCOUNT, wdata);
      no_idle <= (p == 5);
      counted = 0;
      paused = 1'b0;
      while (counted < EVENTS_PER_PHASE) begin
        if (p == 7 && !paused && counted == EVENTS_PER_PHASE / 2) begin
          paused = 1'b1;
          drain_results();
        end
        pick = $urandom_range(0, 99);
        rnd = 16'($urandom_range(0, 65535));
        if (pick < 40) offer_event(gbn_pkg::KIND_SEND, rnd[0], rnd[1], rnd);
        else if (pick < 72) offer_event(gbn_pkg::KIND_ACK, 1'b1, 1'b0, cur_base + 1'b1);
        else if (pick < 80) begin
          if (rnd[15]) offer_event(gbn_pkg::KIND_ACK, rnd[0], rnd[1], rnd);
          else offer_event(gbn_pkg::KIND_ACK, rnd[0], rnd[1], cur_base + 1'b1 + rnd[2]);
        end
        else if (pick < 95) offer_event(gbn_pkg::KIND_TICK, rnd[0], rnd[1], rnd);
        else offer_event(KIND_NONE, rnd[0], rnd[1], rnd);
        if (pick < 95) counted++;
      end
      no_idle <= 1'b0;
    end
  endtask

  always @(posedge clk) out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_status = {send_valid, send_seq, send_last, timed_out, done_res, window_base,
                    outstanding};
      results_seen++;
      if (status_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result %0d arrived with no event pending", results_seen);
      end else begin
        want_status = status_queue.pop_front();
        if (got_status !== want_status) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("result %0d expected: send %0b seq %0d last %0b tmo %0b done %0b",
                     results_seen, want_status.issued, want_status.seq, want_status.last,
                     want_status.expired, want_status.done);
            $display("    expected base %0d out %0d", want_status.base, want_status.count);
            $display("result %0d actual:   send %0b seq %0d last %0b tmo %0b done %0b",
                     results_seen, send_valid, send_seq, send_last, timed_out, done_res);
            $display("    actual base %0d out %0d", window_base, outstanding);
          end
        end
      end
    end
  end

  // Ends the run if no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding", STALL_LIMIT,
               status_queue.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_window_clamp();
    test_stray_acks();
    test_timeouts();
    test_transfer_finished();
    test_random_traffic();
    drain_results();
    $display("%0d events in, %0d results checked, %0d mismatches",
             events_sent, results_seen, mismatches);
    $display("%0d packets issued, %0d acknowledgements taken, %0d window flushes",
             packets, acks, timeouts);
    if (mismatches == 0 && status_queue.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
